// ===== hw/rtl/sigmoid_with_derivative_top_defines.svh =====
// Assertion macros shared by the sigmoid/derivative RTL.
// No dependencies; included by the modules that carry checks.
`ifndef SIGMOID_WITH_DERIVATIVE_TOP_DEFINES_SVH
`define SIGMOID_WITH_DERIVATIVE_TOP_DEFINES_SVH

// same-cycle implication, disabled while reset is low
`define SWD_ASSERT_IMP(name, clk, rst_n, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled while reset is low
`define SWD_ASSERT_NXT(name, clk, rst_n, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hw/rtl/swd_pkg.sv =====
// Shared types and constants for the sigmoid/derivative block.
// No dependencies; imported by swd_core, swd_rq and the top level.
package swd_pkg;

	localparam int SIG_W   = 16;         // result width, unsigned Q0.16
	localparam int Q_AW    = 7;          // result queue address bits
	localparam int Q_DEPTH = 1 << Q_AW;  // result queue entries

	// one result beat from the datapath into the result queue
	typedef struct packed {
		logic             vld;
		logic [SIG_W-1:0] y;
	} res_beat_t;

endpackage

// ===== hw/rtl/swd_core.sv =====
// Fixed-latency datapath: |x| -> exp(-|x|) by series and squaring -> sigmoid divide -> y.
// Depends on swd_pkg. Never stalls; one beat enters per cycle.
module swd_core #(
	parameter int INPUT_BITS = 16
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_vld,
	input  logic signed [INPUT_BITS-1:0] x,
	input  logic                     derivative_mode,
	output swd_pkg::res_beat_t       res
);
	import swd_pkg::*;

	localparam int LAT = 70;  // register stages from input to result

	typedef struct packed {
		logic        neg;
		logic [31:0] u;
		logic [33:0] sum;
		logic [31:0] term;
	} tay_t;

	typedef struct packed {
		logic        neg;
		logic [31:0] u;
		logic [33:0] sum;
		logic [31:0] p;
	} tmul_t;

	typedef struct packed {
		logic        neg;
		logic [34:0] dd;
		logic [49:0] rem;
		logic [16:0] q;
	} div_t;

	localparam logic [33:0] ONE_Q32  = 34'h1_0000_0000;
	localparam logic [63:0] HALF_Q32 = 64'h0000_0000_8000_0000;

	logic [LAT-1:0]        stg_vld_q;
	logic [INPUT_BITS-1:0] x_raw;
	logic [INPUT_BITS-1:0] x_neg;
	logic [INPUT_BITS-1:0] mag;
	logic [INPUT_BITS-1:0] mag_lim;
	logic [15:0]           t;
	tay_t                  tay_s [1:16];
	logic [33:0]           sum_f;
	logic [32:0]           e_s [0:4];
	logic                  neg_e_s [0:4];
	logic [33:0]           d_in;
	div_t                  dv_in;
	div_t                  dv_s [0:16];
	logic [16:0]           s_neg;
	logic [15:0]           ysig_nx;
	logic [15:0]           ysig_s68;
	logic [32:0]           dprod;
	logic [15:0]           res_y_s69;

	// valid bits only; payload follows without enables
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stg_vld_q <= '0;
		end else begin
			stg_vld_q <= {stg_vld_q[LAT-2:0], in_vld};
		end
	end

	// magnitude, clamped to the positive range and to 16 bits
	assign x_raw   = x;
	assign x_neg   = ~x_raw + 1'b1;
	assign mag     = x_raw[INPUT_BITS-1] ? x_neg : x_raw;
	assign mag_lim = mag[INPUT_BITS-1] ? {1'b0, {(INPUT_BITS-1){1'b1}}} : mag;

	generate
		if (INPUT_BITS > 17) begin : g_wide
			assign t = (|mag_lim[INPUT_BITS-1:16]) ? 16'hFFFF : mag_lim[15:0];
		end else begin : g_narrow
			assign t = 16'(mag_lim);
		end
	endgenerate

	// stage 0: term 1 is u itself, sum still holds term 0
	always_ff @(posedge clk) begin
		tay_s[1].neg  <= x_raw[INPUT_BITS-1];
		tay_s[1].u    <= {t, 16'h0000};
		tay_s[1].sum  <= ONE_Q32;
		tay_s[1].term <= {t, 16'h0000};
	end

	// series terms 2..16, three stages each:
	// multiply by u, reciprocal multiply, remainder fixup with round half up
	generate
		for (genvar k = 2; k <= 16; k++) begin : g_term
			localparam logic [31:0] RECIP = 32'((64'd1 << 32) / k);
			localparam logic [5:0]  KDIV  = 6'(k);
			localparam logic [5:0]  KDIV2 = 6'(2 * k);
			localparam logic [5:0]  KHALF = 6'(k / 2);
			localparam bit          SUB   = ((k % 2) == 0);

			tmul_t       a_s1;
			tmul_t       b_s2;
			logic [31:0] qe_s2;
			logic [63:0] pa;
			logic [63:0] pb;
			logic [33:0] sum_nx;
			logic [5:0]  rem6;
			logic [5:0]  rsum;
			logic [1:0]  inc;
			logic [31:0] q_nx;

			assign pa = 64'(tay_s[k-1].term) * 64'(tay_s[k-1].u);

			// fold the previous term into the running sum; odd terms subtract, floor 0
			if (SUB) begin : g_sub
				assign sum_nx = (34'(tay_s[k-1].term) > tay_s[k-1].sum) ? '0 :
					tay_s[k-1].sum - 34'(tay_s[k-1].term);
			end else begin : g_add
				assign sum_nx = tay_s[k-1].sum + 34'(tay_s[k-1].term);
			end

			always_ff @(posedge clk) begin
				a_s1.neg <= tay_s[k-1].neg;
				a_s1.u   <= tay_s[k-1].u;
				a_s1.sum <= sum_nx;
				a_s1.p   <= 32'((pa + HALF_Q32) >> 32);
			end

			// estimate is floor(p/k) or one below
			assign pb = 64'(a_s1.p) * 64'(RECIP);

			always_ff @(posedge clk) begin
				b_s2  <= a_s1;
				qe_s2 <= pb[63:32];
			end

			// remainder lies below 2k, so six bits carry it
			assign rem6 = b_s2.p[5:0] - (qe_s2[5:0] * KDIV);
			assign rsum = rem6 + KHALF;

			always_comb begin
				priority if (rsum >= KDIV2) begin
					inc = 2'd2;
				end else if (rsum >= KDIV) begin
					inc = 2'd1;
				end else begin
					inc = 2'd0;
				end
			end

			assign q_nx = qe_s2 + 32'(inc);

			always_ff @(posedge clk) begin
				tay_s[k].neg  <= b_s2.neg;
				tay_s[k].u    <= b_s2.u;
				tay_s[k].sum  <= b_s2.sum;
				tay_s[k].term <= q_nx;
			end
		end
	endgenerate

	// stage 46: last term, clamp to 1.0
	assign sum_f = tay_s[16].sum + 34'(tay_s[16].term);

	always_ff @(posedge clk) begin
		e_s[0]     <= (sum_f > ONE_Q32) ? ONE_Q32[32:0] : sum_f[32:0];
		neg_e_s[0] <= tay_s[16].neg;
	end

	// stages 47..50: four squarings take exp(-t/16) to exp(-t); 1.0 passes
	generate
		for (genvar j = 1; j <= 4; j++) begin : g_sq
			logic [63:0] ps;

			assign ps = 64'(e_s[j-1][31:0]) * 64'(e_s[j-1][31:0]);

			always_ff @(posedge clk) begin
				e_s[j]     <= e_s[j-1][32] ? e_s[j-1] :
					{1'b0, 32'((ps + HALF_Q32) >> 32)};
				neg_e_s[j] <= neg_e_s[j-1];
			end
		end
	endgenerate

	// s = floor((2^49 + d) / 2d), d = 1.0 + e
	assign d_in      = ONE_Q32 + 34'(e_s[4]);
	assign dv_in.neg = neg_e_s[4];
	assign dv_in.dd  = {d_in, 1'b0};
	assign dv_in.rem = 50'h2_0000_0000_0000 + 50'(d_in);
	assign dv_in.q   = '0;

	// stages 51..67: restoring divide, one quotient bit per stage, MSB first
	generate
		for (genvar i = 16; i >= 0; i--) begin : g_div
			div_t        src;
			logic [50:0] sh;
			logic        ge;

			if (i == 16) begin : g_first
				assign src = dv_in;
			end else begin : g_next
				assign src = dv_s[i+1];
			end

			assign sh = 51'(src.dd) << i;
			assign ge = {1'b0, src.rem} >= sh;

			always_ff @(posedge clk) begin
				dv_s[i].neg <= src.neg;
				dv_s[i].dd  <= src.dd;
				dv_s[i].rem <= ge ? 50'({1'b0, src.rem} - sh) : src.rem;
				dv_s[i].q   <= src.q | (17'(ge) << i);
			end
		end
	endgenerate

	// stage 68: fold sign back in, saturate 1.0
	assign s_neg   = 17'h1_0000 - dv_s[0].q;
	assign ysig_nx = dv_s[0].neg ? s_neg[15:0] :
		(dv_s[0].q[16] ? 16'hFFFF : dv_s[0].q[15:0]);

	always_ff @(posedge clk) begin
		ysig_s68 <= ysig_nx;
	end

	// stage 69: y = s or derivative s*(1-s) by mode, peak 0.25 so 16 bits hold it
	assign dprod = 33'(ysig_s68) * 33'(17'h1_0000 - 17'(ysig_s68));

	always_ff @(posedge clk) begin
		res_y_s69 <= derivative_mode ? dprod[31:16] : ysig_s68;
	end

	assign res.vld = stg_vld_q[LAT-1];
	assign res.y   = res_y_s69;

endmodule

// ===== hw/rtl/swd_rq.sv =====
// Result queue: single-port-per-side memory with registered read feeding the output.
// Depends on swd_pkg and the assertion macro header.
`include "sigmoid_with_derivative_top_defines.svh"

module swd_rq (
	input  logic                      clk,
	input  logic                      arst_n,
	input  swd_pkg::res_beat_t        res,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic [swd_pkg::SIG_W-1:0] y
);
	import swd_pkg::*;

	logic [SIG_W-1:0] mem [Q_DEPTH];
	logic [Q_AW-1:0]  wptr_q;
	logic [Q_AW-1:0]  rptr_q;
	logic [Q_AW:0]    cnt_q;
	logic             vld_q;
	logic [SIG_W-1:0] rd_q;
	logic             ld;

	// read straight into the output register when it is empty or draining
	assign ld = (cnt_q != '0) && (!vld_q || out_ready);

	always_ff @(posedge clk) begin
		if (res.vld) begin
			mem[wptr_q] <= res.y;
		end
	end

	always_ff @(posedge clk) begin
		if (ld) begin
			rd_q <= mem[rptr_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
			vld_q  <= 1'b0;
		end else begin
			if (res.vld) begin
				wptr_q <= wptr_q + 1'b1;
			end
			if (ld) begin
				rptr_q <= rptr_q + 1'b1;
			end
			cnt_q <= cnt_q + (Q_AW+1)'(res.vld) - (Q_AW+1)'(ld);
			priority if (ld) begin
				vld_q <= 1'b1;
			end else if (out_ready) begin
				vld_q <= 1'b0;
			end else begin
				vld_q <= vld_q;
			end
		end
	end

	assign out_valid = vld_q;
	assign y         = rd_q;

	`SWD_ASSERT_IMP(a_rq_no_overflow, clk, arst_n, res.vld, cnt_q < (Q_AW+1)'(Q_DEPTH), "result queue written while full")
	`SWD_ASSERT_NXT(a_rq_refill, clk, arst_n, vld_q && out_ready && (cnt_q != '0), vld_q, "output gap while queue holds beats")
	`SWD_ASSERT_NXT(a_rq_fill, clk, arst_n, !vld_q && (cnt_q != '0), vld_q, "output register left empty")

endmodule

// ===== hw/rtl/sigmoid_with_derivative_top.sv =====
// A result passes the datapath and the result queue memory into the output register (out_valid).
// Throughput: one beat per cycle while in_ready is high; 70-stage datapath, 128-entry queue.
// in_ready drops only when 128 beats are in flight, i.e. while the output side stalls.
// Reset (arst_n low, asynchronous): pipeline valids, queue pointers, credit count cleared;
// derivative_mode register returns to 0 (sigmoid). Queue memory contents are not cleared.
// Depends on swd_pkg, swd_core, swd_rq and the assertion macro header.
`include "sigmoid_with_derivative_top_defines.svh"

module sigmoid_with_derivative_top #(
	parameter int INPUT_BITS = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	// input channel: one signed element per beat, 12 fraction bits
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic signed [INPUT_BITS-1:0] x,
	// output channel: unsigned Q0.16 result per beat
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [swd_pkg::SIG_W-1:0]    y,
	// configuration write: derivative_mode register
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic                         derivative_mode
);
	import swd_pkg::*;

	logic          in_acc;
	logic          out_acc;
	logic [Q_AW:0] inflight_q;
	logic          derivative_mode_q;
	res_beat_t     core_res;

	assign in_acc  = in_valid && in_ready;
	assign out_acc = out_valid && out_ready;

	// Credit scheme: every beat taken holds a queue slot until its result beat
	// leaves. The datapath never stalls, so the queue cannot overflow as long
	// as in-flight beats stay at or below the queue depth.
	assign in_ready  = inflight_q < (Q_AW+1)'(Q_DEPTH);
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inflight_q        <= '0;
			derivative_mode_q <= 1'b0;
		end else begin
			inflight_q <= inflight_q + (Q_AW+1)'(in_acc) - (Q_AW+1)'(out_acc);
			if (cfg_valid) begin
				derivative_mode_q <= derivative_mode;
			end
		end
	end

	// exp series, squarings and divide; mode applied at the last stage
	swd_core #(
		.INPUT_BITS (INPUT_BITS)
	) u_core (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_vld          (in_acc),
		.x               (x),
		.derivative_mode (derivative_mode_q),
		.res             (core_res)
	);

	// result memory and output register
	swd_rq u_rq (
		.clk       (clk),
		.arst_n    (arst_n),
		.res       (core_res),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.y         (y)
	);

	`SWD_ASSERT_IMP(a_credit_bound, clk, arst_n, 1'b1, inflight_q <= (Q_AW+1)'(Q_DEPTH), "credit count above queue depth")
	`SWD_ASSERT_IMP(a_out_has_credit, clk, arst_n, out_valid, inflight_q != '0, "result beat with nothing in flight")
	`SWD_ASSERT_IMP(a_core_has_credit, clk, arst_n, core_res.vld, inflight_q != '0, "datapath result with nothing in flight")

endmodule

// ===== verif/sigmoid_deriv_checker.sv =====
`timescale 1ns / 100ps
// Scoreboard for sigmoid_with_derivative_top: follows the mode register, predicts y for each
// input beat and checks output beats in order. Depends on swd_pkg (result width) only.
module sigmoid_deriv_checker #(
	parameter int XW = 16
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	input  logic                      in_ready,
	input  logic signed [XW-1:0]      x,
	input  logic                      out_valid,
	input  logic                      out_ready,
	input  logic [swd_pkg::SIG_W-1:0] y,
	input  logic                      cfg_valid,
	input  logic                      cfg_ready,
	input  logic                      derivative_mode,
	output int                        fail_count,
	output int                        pending,
	output int                        result_count
);
	import swd_pkg::*;

	localparam logic [63:0] Q32_ONE      = 64'd1 << 32;
	localparam logic [63:0] Q32_HALF     = 64'd1 << 31;
	localparam int          TAYLOR_ORDER = 16;
	localparam int          SQUARE_STEPS = 4;
	localparam int          PRINT_MAX    = 25;

	typedef struct {
		logic [XW-1:0]    x;
		logic             deriv;
		logic [SIG_W-1:0] y;
	} sig_expect_t;

	sig_expect_t expected_y[$];
	logic        deriv_mode = 1'b0;
	int          errs = 0;
	int          results = 0;

	// exp(-|x|) via Taylor series at |x|/16, squared four times, Q0.32; then sigmoid/derivative
	function automatic logic [SIG_W-1:0] logistic_q16(logic [XW-1:0] raw, logic deriv);
		logic [63:0] mag, u, term, sum, d, s, val;
		logic        neg;
		neg = raw[XW-1];
		mag = 64'(raw);
		if (neg)
			mag = (64'd1 << XW) - mag;
		if (mag > (64'd1 << (XW - 1)) - 64'd1)
			mag = (64'd1 << (XW - 1)) - 64'd1;
		if (mag > 64'hFFFF)
			mag = 64'hFFFF;
		u    = mag << 16;
		term = Q32_ONE;
		sum  = Q32_ONE;
		for (int k = 1; k <= TAYLOR_ORDER; k++) begin
			term = (term * u + Q32_HALF) >> 32;
			term = (term + 64'(k / 2)) / 64'(k);
			if (k % 2 == 1)
				sum = (term > sum) ? 64'd0 : sum - term;
			else
				sum = sum + term;
		end
		if (sum > Q32_ONE)
			sum = Q32_ONE;
		for (int i = 0; i < SQUARE_STEPS; i++) begin
			if (sum < Q32_ONE)
				sum = (sum * sum + Q32_HALF) >> 32;
		end
		d = Q32_ONE + sum;
		s = ((64'd1 << 49) + d) / (d << 1);
		if (neg)
			val = 64'd65536 - s;
		else
			val = (s > 64'd65535) ? 64'd65535 : s;
		if (deriv)
			val = (val * (64'd65536 - val)) >> 16;
		return val[SIG_W-1:0];
	endfunction

	task automatic report_mismatch(string what, logic [XW-1:0] xin, logic [SIG_W-1:0] got,
			logic [SIG_W-1:0] want);
		errs++;
		if (errs <= PRINT_MAX)
			$display("[%0t] %s: x=%h y=%h expected %h", $time, what, xin, got, want);
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		sig_expect_t head;
		if (!arst_n) begin
			deriv_mode = 1'b0;
		end else begin
			if (cfg_valid && cfg_ready)
				deriv_mode = derivative_mode;
			if (in_valid && in_ready)
				expected_y.push_back('{x: x, deriv: deriv_mode, y: logistic_q16(x, deriv_mode)});
			if (out_valid && out_ready) begin
				results++;
				if (expected_y.size() == 0) begin
					report_mismatch("result beat with none expected", '0, y, '0);
				end else begin
					head = expected_y.pop_front();
					if (y !== head.y)
						report_mismatch(head.deriv ? "derivative mismatch" : "sigmoid mismatch",
							head.x, y, head.y);
				end
			end
		end
		fail_count   <= errs;
		pending      <= expected_y.size();
		result_count <= results;
	end

endmodule

// ===== verif/tb_sigmoid_with_derivative_top.sv =====
`timescale 1ns / 100ps
// Top of the sigmoid/derivative testbench: clock, reset, stimulus, output back-pressure, verdict.
// Depends on swd_pkg, sigmoid_with_derivative_top and sigmoid_deriv_checker.
module tb_sigmoid_with_derivative_top;
	import swd_pkg::*;

	localparam int   XW           = 16;
	localparam logic MODE_SIGMOID = 1'b0;
	localparam logic MODE_DERIV   = 1'b1;
	localparam int   GAP_MAX      = 6;
	// forced output hold: long enough that 128 beats pile up and in_ready drops
	localparam int   HOLD_CYCLES  = 700;
	localparam int   HOLD_AFTER   = 100;  // results taken before the hold starts
	// tail after the last expected beat
	localparam int   TAIL_CYCLES  = 90;
	// longest correct quiet stretch is the hold above; take it several times over
	localparam int   QUIET_LIMIT  = 5000;

	// corner elements: zero, +-1 lsb, +-0.5, +-1.0, +-2, +-4, +-6, +7, both ends of the range
	// (most negative gets its magnitude clamped), alternating bit patterns
	localparam logic [XW-1:0] EDGE_X [21] = '{
		16'h0000, 16'h0001, 16'hFFFF, 16'h0800, 16'hF800, 16'h1000, 16'hF000,
		16'h2000, 16'hE000, 16'h4000, 16'hC000, 16'h6000, 16'hA000, 16'h7000,
		16'h7FFF, 16'h8001, 16'h8000, 16'h5555, 16'hAAAA, 16'h0FFF, 16'hF001
	};

	logic                 clk             = 1'b0;
	logic                 arst_n          = 1'b0;
	logic                 in_valid        = 1'b0;
	logic signed [XW-1:0] x               = '0;
	logic                 out_ready       = 1'b0;
	logic                 cfg_valid       = 1'b0;
	logic                 derivative_mode = 1'b0;
	logic                 in_ready;
	logic                 out_valid;
	logic                 cfg_ready;
	logic [SIG_W-1:0]     y;

	int fail_count;
	int pending;
	int result_count;
	int sent        = 0;
	int taken       = 0;
	int mode_writes = 0;
	int quiet       = 0;
	bit hold_done   = 1'b0;

	sigmoid_with_derivative_top #(
		.INPUT_BITS(XW)
	) dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.x              (x),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.y              (y),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.derivative_mode(derivative_mode)
	);

	sigmoid_deriv_checker #(
		.XW(XW)
	) u_check (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.x              (x),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.y              (y),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.derivative_mode(derivative_mode),
		.fail_count     (fail_count),
		.pending        (pending),
		.result_count   (result_count)
	);

	// 12 ns clock
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// watchdog: any beat on any channel restarts the count
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
				(cfg_valid && cfg_ready)) begin
			quiet <= 0;
		end else if (quiet >= QUIET_LIMIT) begin
			$display("watchdog: %0d cycles without a beat, %0d results outstanding", quiet, pending);
			$display("== FAIL ==");
			$finish;
		end else begin
			quiet <= quiet + 1;
		end
	end

	// Random element: half raw 16-bit words (every bit toggles), a good share of
	// small magnitudes where the curve actually bends, and now and then a corner value.
	function automatic logic signed [XW-1:0] rand_x();
		logic [XW-1:0] mag;
		unique case ($urandom_range(0, 7))
			0, 1, 2, 3: return XW'($urandom);
			4, 5, 6: begin
				mag = XW'($urandom_range(0, 8191));
				return $urandom_range(0, 1) ? -mag : mag;
			end
			default: return EDGE_X[$urandom_range(0, $size(EDGE_X) - 1)];
		endcase
	endfunction

	// One input beat. valid stays up across back-to-back beats; it only drops for a gap.
	// Every third stretch of 50 beats runs with no gaps at all.
	task automatic send_x(input logic signed [XW-1:0] v);
		int gap;
		gap = ((sent / 50) % 3 == 1) ? 0 : $urandom_range(0, GAP_MAX);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		x        <= v;
		do @(posedge clk); while (!in_ready);
		sent++;
	endtask

	// every beat sent has come back (the checker's count is registered, which is harmless)
	task automatic wait_idle();
		do @(posedge clk); while (pending != 0);
	endtask

	// mode changes only with the pipe empty
	task automatic set_mode(input logic m);
		in_valid <= 1'b0;
		wait_idle();
		cfg_valid       <= 1'b1;
		derivative_mode <= m;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		mode_writes++;
	endtask

	// Output side: random stall before each beat, every third stretch of 40 beats
	// without stalls, and once a long hold so the result queue fills and in_ready drops
	// while the sender keeps offering.
	initial begin : result_sink
		int stall;
		wait (arst_n === 1'b1);
		forever begin
			if (!hold_done && taken >= HOLD_AFTER) begin
				hold_done = 1'b1;
				stall     = HOLD_CYCLES;
			end else if ((taken / 40) % 3 == 2) begin
				stall = 0;
			end else begin
				stall = $urandom_range(0, GAP_MAX);
			end
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
			taken++;
		end
	end

	initial begin : stimulus
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// corners in both modes
		set_mode(MODE_SIGMOID);
		foreach (EDGE_X[i]) send_x(EDGE_X[i]);
		set_mode(MODE_DERIV);
		foreach (EDGE_X[i]) send_x(EDGE_X[i]);

		// random phases, mode flipped between them; the output hold lands in the first
		set_mode(MODE_SIGMOID);
		repeat (280) send_x(rand_x());
		set_mode(MODE_DERIV);
		repeat (230) send_x(rand_x());
		set_mode(MODE_SIGMOID);
		repeat (200) send_x(rand_x());
		set_mode(MODE_DERIV);
		repeat (200) send_x(rand_x());

		in_valid <= 1'b0;
		wait_idle();
		// catch any stray beat after the last expected one
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("covered %0d elements, %0d results checked, %0d mode writes (sigmoid and derivative)",
			sent, result_count, mode_writes);
		$display("corner values in both modes, random gaps on both sides, one %0d-cycle output hold",
			HOLD_CYCLES);
		if (fail_count == 0 && pending == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

// ===== sigmoid_with_derivative_top.f =====
+incdir+hw/rtl
hw/rtl/swd_pkg.sv
hw/rtl/swd_core.sv
hw/rtl/swd_rq.sv
hw/rtl/sigmoid_with_derivative_top.sv
verif/sigmoid_deriv_checker.sv
verif/tb_sigmoid_with_derivative_top.sv
